/* hw/rtl/swfr_pkg.sv */
// Shared types and constants for the sliding window frame receiver.
`default_nettype none
package swfr_pkg;

  localparam int SEQ_W    = 5;
  localparam int SPACE_W  = SEQ_W + 1;
  localparam int SLOTS    = 1 << SEQ_W;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 7;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [SEQ_W-1:0] MAX_WINDOW = SEQ_W'(16);
  localparam logic [SEQ_W-1:0] RESET_WINDOW = SEQ_W'(4);

  typedef enum logic [1:0] {
    CMD_ACK,
    CMD_STORE,
    CMD_DELIVER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [SEQ_W-1:0]     seq;
    logic [HANDLE_W-1:0]  handle;
    logic [LEN_W-1:0]     len;
    logic [SLOTS-1:0]     mask;
    logic [SEQ_W-1:0]     win;
    logic [SPACE_W-1:0]   space;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [SEQ_W-1:0]     next_exp;
    logic [SLOTS-1:0]     clr;
  } done_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT,
    BK_ACK
  } back_state_t;

  localparam logic RES_DELIVER = 1'b0;
  localparam logic RES_ACK     = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/swfr_front.sv */
// Front end: window check, duplicate filter, mark tracking and command issue.
`default_nettype none
module swfr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [swfr_pkg::SEQ_W-1:0]    in_seq_no,
  input  wire logic [swfr_pkg::HANDLE_W-1:0] in_payload_handle,
  input  wire logic [swfr_pkg::LEN_W-1:0]    in_payload_length,
  input  wire logic                          cfg_we,
  input  wire logic [swfr_pkg::SEQ_W-1:0]    cfg_wdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output swfr_pkg::cmd_t                     q_cmd,
  input  wire swfr_pkg::done_t               done
);
  import swfr_pkg::*;

  logic [SEQ_W-1:0]   win_r, win_nxt;
  logic [SEQ_W-1:0]   exp_r, exp_nxt;
  logic [SLOTS-1:0]   mask_r, mask_nxt;
  logic               busy_r, busy_nxt;

  logic [SEQ_W-1:0]   w;
  logic [SPACE_W-1:0] space;
  logic [SPACE_W:0]   sum;
  logic [SPACE_W:0]   offset;
  logic               accept;
  logic               outside;
  logic               dup;
  logic [SLOTS-1:0]   bit_sel;

  always_comb begin
    if (win_r == '0) begin
      w = SEQ_W'(1);
    end else if (win_r > MAX_WINDOW) begin
      w = MAX_WINDOW;
    end else begin
      w = win_r;
    end
    space   = {w, 1'b0};
    sum     = {2'b00, in_seq_no} + {1'b0, space} - {2'b00, exp_r};
    offset  = (sum >= {1'b0, space}) ? (sum - {1'b0, space}) : sum;
    outside = ({1'b0, in_seq_no} >= space) || (offset >= {2'b00, w});
    bit_sel = SLOTS'(1) << in_seq_no;
    dup     = (mask_r & bit_sel) != '0;

    full   = busy_r || q_full;
    accept = push && !full;

    q_cmd.kind   = CMD_ACK;
    q_cmd.seq    = in_seq_no;
    q_cmd.handle = in_payload_handle;
    q_cmd.len    = in_payload_length;
    q_cmd.mask   = mask_r | bit_sel;
    q_cmd.win    = w;
    q_cmd.space  = space;
    q_push       = 1'b0;

    win_nxt  = win_r;
    exp_nxt  = exp_r;
    mask_nxt = mask_r;
    busy_nxt = busy_r;

    if (done.valid) begin
      mask_nxt = mask_nxt & ~done.clr;
      exp_nxt  = done.next_exp;
      busy_nxt = 1'b0;
    end

    if (accept) begin
      if (outside) begin
        q_push = 1'b1;
      end else if (!dup) begin
        q_push   = 1'b1;
        mask_nxt = mask_nxt | bit_sel;
        if (in_seq_no == exp_r) begin
          q_cmd.kind = CMD_DELIVER;
          busy_nxt   = 1'b1;
        end else begin
          q_cmd.kind = CMD_STORE;
        end
      end
    end

    if (cfg_we) begin
      win_nxt  = cfg_wdata;
      exp_nxt  = '0;
      mask_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= RESET_WINDOW;
      exp_r  <= '0;
      mask_r <= '0;
      busy_r <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      exp_r  <= exp_nxt;
      mask_r <= mask_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/swfr_cmdq.sv */
// Short command queue between the front end and the delivery engine.
`default_nettype none
module swfr_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire swfr_pkg::cmd_t wr_cmd,
  output logic                q_full,
  input  wire logic           rd_en,
  output swfr_pkg::cmd_t      rd_cmd,
  output logic                q_empty
);
  import swfr_pkg::*;

  cmd_t                entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    q_full  = cnt_r == QCNT_W'(QDEPTH);
    q_empty = cnt_r == '0;
    do_wr   = wr_en && !q_full;
    do_rd   = rd_en && !q_empty;
    rd_cmd  = entry_r[rp_r];
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/swfr_back.sv */
// Delivery engine: slot memory, in-order scan and result register.
`default_nettype none
module swfr_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire swfr_pkg::cmd_t                 q_cmd,
  output logic                                q_pop,
  output swfr_pkg::done_t                     done,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                out_kind,
  output logic [swfr_pkg::SEQ_W-1:0]          out_ack_or_seq,
  output logic [swfr_pkg::HANDLE_W-1:0]       out_handle,
  output logic [swfr_pkg::LEN_W-1:0]          out_length,
  output logic                                out_last
);
  import swfr_pkg::*;

  logic [HANDLE_W+LEN_W-1:0] mem [SLOTS];
  logic [HANDLE_W+LEN_W-1:0] rd_r;

  back_state_t         state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [SEQ_W-1:0]    cur_r, cur_nxt;
  logic [SEQ_W-1:0]    n_r, n_nxt;
  logic [SLOTS-1:0]    mask_r, mask_nxt;
  logic [SEQ_W-1:0]    last_r, last_nxt;

  logic                ov_r, ov_nxt;
  logic                okind_r, okind_nxt;
  logic [SEQ_W-1:0]    oseq_r, oseq_nxt;
  logic [HANDLE_W-1:0] ohandle_r, ohandle_nxt;
  logic [LEN_W-1:0]    olen_r, olen_nxt;
  logic                olast_r, olast_nxt;

  logic                out_free;
  logic                wr_en;
  logic                rd_en;
  logic [SEQ_W-1:0]    cur_inc;

  always_comb begin
    out_free = !ov_r || pop;
    cur_inc  = ({1'b0, cur_r} + SPACE_W'(1) == cmd_r.space) ? '0 : cur_r + SEQ_W'(1);

    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cur_nxt     = cur_r;
    n_nxt       = n_r;
    mask_nxt    = mask_r;
    last_nxt    = last_r;
    okind_nxt   = okind_r;
    oseq_nxt    = oseq_r;
    ohandle_nxt = ohandle_r;
    olen_nxt    = olen_r;
    olast_nxt   = olast_r;
    ov_nxt      = ov_r && !pop;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    done.valid    = 1'b0;
    done.next_exp = cur_r;
    done.clr      = cmd_r.mask & ~mask_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.kind)
            CMD_ACK: begin
              if (out_free) begin
                q_pop       = 1'b1;
                ov_nxt      = 1'b1;
                okind_nxt   = RES_ACK;
                oseq_nxt    = q_cmd.seq;
                ohandle_nxt = '0;
                olen_nxt    = '0;
                olast_nxt   = 1'b1;
              end
            end
            CMD_STORE: begin
              q_pop = 1'b1;
              wr_en = 1'b1;
            end
            CMD_DELIVER: begin
              q_pop     = 1'b1;
              wr_en     = 1'b1;
              cmd_nxt   = q_cmd;
              cur_nxt   = q_cmd.seq;
              n_nxt     = '0;
              mask_nxt  = q_cmd.mask;
              last_nxt  = q_cmd.seq;
              state_nxt = BK_SCAN;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if ((n_r < cmd_r.win) && mask_r[cur_r]) begin
          rd_en     = 1'b1;
          state_nxt = BK_EMIT;
        end else begin
          state_nxt = BK_ACK;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          ov_nxt          = 1'b1;
          okind_nxt       = RES_DELIVER;
          oseq_nxt        = cur_r;
          ohandle_nxt     = rd_r[HANDLE_W+LEN_W-1:LEN_W];
          olen_nxt        = rd_r[LEN_W-1:0];
          olast_nxt       = 1'b0;
          mask_nxt[cur_r] = 1'b0;
          last_nxt        = cur_r;
          cur_nxt         = cur_inc;
          n_nxt           = n_r + SEQ_W'(1);
          state_nxt       = BK_SCAN;
        end
      end
      BK_ACK: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          okind_nxt   = RES_ACK;
          oseq_nxt    = last_r;
          ohandle_nxt = '0;
          olen_nxt    = '0;
          olast_nxt   = 1'b1;
          done.valid  = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    empty          = !ov_r;
    out_kind       = okind_r;
    out_ack_or_seq = oseq_r;
    out_handle     = ohandle_r;
    out_length     = olen_r;
    out_last       = olast_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_cmd.seq] <= {q_cmd.handle, q_cmd.len};
    end
    if (rd_en) begin
      rd_r <= mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cur_r     <= cur_nxt;
    n_r       <= n_nxt;
    mask_r    <= mask_nxt;
    last_r    <= last_nxt;
    okind_r   <= okind_nxt;
    oseq_r    <= oseq_nxt;
    ohandle_r <= ohandle_nxt;
    olen_r    <= olen_nxt;
    olast_r   <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_emit_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> mask_r[cur_r])
    else $error("emit of an unmarked slot");

  a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (okind_r == olast_r))
    else $error("last flag does not match result kind");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> (n_r <= cmd_r.win))
    else $error("delivery run longer than the window");

  a_scan_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |-> (cmd_r.kind == CMD_DELIVER))
    else $error("scan without a deliver command");

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_frame_receiver_unit.sv */
// Top level of the sliding window frame receiver.
//
// Input channel: one word per arriving frame (sequence number, payload handle,
// length), taken on a clock edge with push high and full low.
// Result channel: words of delivered frames and acknowledgements, oldest on the
// out_ ports while empty is low, taken on an edge with pop high.
// Configuration: cfg_we writes the window size and restarts the window at 0.
// Timing: an accepted frame that is not a duplicate enters the command queue at
// the accepting edge; a duplicate is dropped. An ACK word passes from the queue
// through the delivery engine into the result register. A frame that only fills
// a gap is written to the slot memory, so such frames can follow one per cycle
// while nothing ahead of them waits on the result register. An in-order frame
// starts a run over the slot memory's single read port (one read, then one
// result word per slot, then an ACK word); full stays high until the run ends.
// Reset: clears the window, all marks, the command queue and the result
// register; window size returns to 4.
// Stall: a result word holds while pop is low; the engine stops at the next
// command that needs the result register and full rises once the queue fills.
`default_nettype none
module sliding_window_frame_receiver_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [swfr_pkg::SEQ_W-1:0]    in_seq_no,
  input  wire logic [swfr_pkg::HANDLE_W-1:0] in_payload_handle,
  input  wire logic [swfr_pkg::LEN_W-1:0]    in_payload_length,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               out_kind,
  output logic [swfr_pkg::SEQ_W-1:0]         out_ack_or_seq,
  output logic [swfr_pkg::HANDLE_W-1:0]      out_handle,
  output logic [swfr_pkg::LEN_W-1:0]         out_length,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [swfr_pkg::SEQ_W-1:0]    cfg_wdata
);
  import swfr_pkg::*;

  cmd_t  f_cmd;
  cmd_t  b_cmd;
  done_t done;
  logic  f_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  swfr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_seq_no         (in_seq_no),
    .in_payload_handle (in_payload_handle),
    .in_payload_length (in_payload_length),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_full            (q_full),
    .q_push            (f_push),
    .q_cmd             (f_cmd),
    .done              (done)
  );

  swfr_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_cmd  (f_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (b_cmd),
    .q_empty (q_empty)
  );

  swfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (b_cmd),
    .q_pop          (q_pop),
    .done           (done),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .out_ack_or_seq (out_ack_or_seq),
    .out_handle     (out_handle),
    .out_length     (out_length),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
